// ----- rtl/core/length_prefixed_command_deframer_assert.svh -----
// ----------------------------------------------------------------------------
// Deframer assertion macros
// Concurrent assertion wrappers; they compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef LENGTH_PREFIXED_COMMAND_DEFRAMER_ASSERT_SVH
`define LENGTH_PREFIXED_COMMAND_DEFRAMER_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define LPCD_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lpcd: same-cycle check failed");

// next-cycle implication
`define LPCD_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lpcd: next-cycle check failed");

`else

`define LPCD_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define LPCD_ASSERT_NXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ----- rtl/core/lpcd_pkg.sv -----
// ----------------------------------------------------------------------------
// lpcd_pkg
// Shared types, field widths and codes of the command frame deframer.
// ----------------------------------------------------------------------------
package lpcd_pkg;

   // frame layout
   localparam int HEADER_BYTES = 20;
   localparam int INDEX_W      = 5;
   localparam logic [INDEX_W-1:0] LAST_HEADER_INDEX = INDEX_W'(HEADER_BYTES - 1);
   localparam logic [INDEX_W-1:0] LAST_LENGTH_INDEX = INDEX_W'(3);
   localparam logic [INDEX_W-1:0] HDR_VERSION_OFS   = INDEX_W'(4);
   localparam logic [INDEX_W-1:0] HDR_TYPE_OFS      = INDEX_W'(6);
   localparam logic [INDEX_W-1:0] HDR_PLEN_OFS      = INDEX_W'(8);
   localparam logic [INDEX_W-1:0] HDR_RID_OFS       = INDEX_W'(12);

   // field widths
   localparam int BYTE_W  = 8;
   localparam int MAGIC_W = 32;
   localparam int VER_W   = 16;
   localparam int TYPE_W  = 16;
   localparam int PLEN_W  = 32;
   localparam int LEN_W   = 24;
   localparam int RID_W   = 64;

   // configuration port
   localparam int CSR_ADDR_W  = 4;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAGIC_WORD       = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_EXPECTED_VERSION = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_PAYLOAD      = 2'd2;
   localparam logic [LEN_W-1:0]       MAX_PAYLOAD_RESET    = 24'd65536;

   typedef enum logic [1:0] {
      PH_LENGTH  = 2'd0,
      PH_HEADER  = 2'd1,
      PH_PAYLOAD = 2'd2
   } phase_type;

   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_BAD_LENGTH  = 3'd1,
      ST_BAD_MAGIC   = 3'd2,
      ST_BAD_VERSION = 3'd3,
      ST_MISMATCH    = 3'd4
   } status_type;

   typedef struct packed {
      logic [BYTE_W-1:0] payload_byte;
      logic              byte_valid;
      logic              frame_end;
      status_type        status;
      logic [TYPE_W-1:0] command_type;
      logic [VER_W-1:0]  header_version;
      logic [LEN_W-1:0]  payload_length;
      logic [RID_W-1:0]  request_tag;
   } rsp_type;

endpackage

// ----- rtl/core/lpcd_req_if.sv -----
// ----------------------------------------------------------------------------
// lpcd_req_if
// Byte stream channel into the deframer: one stream byte or a restart a beat.
// ----------------------------------------------------------------------------
interface lpcd_req_if import lpcd_pkg::*; ();

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;
   logic              restart;

   modport source (output valid, output data_byte, output restart, input ready);
   modport sink   (input valid, input data_byte, input restart, output ready);

endinterface

// ----- rtl/core/lpcd_rsp_if.sv -----
// ----------------------------------------------------------------------------
// lpcd_rsp_if
// Result channel of the deframer: payload bytes and end-of-frame verdicts.
// ----------------------------------------------------------------------------
interface lpcd_rsp_if import lpcd_pkg::*; ();

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] payload_byte;
   logic              byte_valid;
   logic              frame_end;
   logic [2:0]        status;
   logic [TYPE_W-1:0] command_type;
   logic [VER_W-1:0]  header_version;
   logic [LEN_W-1:0]  payload_length;
   logic [RID_W-1:0]  request_tag;

   modport source (
      output valid, output payload_byte, output byte_valid, output frame_end,
      output status, output command_type, output header_version,
      output payload_length, output request_tag, input ready
   );
   modport sink (
      input valid, input payload_byte, input byte_valid, input frame_end,
      input status, input command_type, input header_version,
      input payload_length, input request_tag, output ready
   );

endinterface

// ----- rtl/core/length_prefixed_command_deframer.sv -----
// ----------------------------------------------------------------------------
// length_prefixed_command_deframer: an accepted beat's result goes straight
// into the output register; throughput is one beat per cycle while the output
// register is free or drains, set by the single frame-state update in between.
// Synchronous active-high reset: length phase, no result pending, registers
// magic_word 0, expected_version 0, max_payload 65536.
// ----------------------------------------------------------------------------
`include "length_prefixed_command_deframer_assert.svh"

module length_prefixed_command_deframer import lpcd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   lpcd_req_if.sink              req_if,
   lpcd_rsp_if.source            rsp_if,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   // configuration registers
   logic [MAGIC_W-1:0] magic_word_ff;
   logic [VER_W-1:0]   expected_version_ff;
   logic [LEN_W-1:0]   max_payload_ff;

   // frame state
   phase_type          phase_ff, phase_in;
   logic [INDEX_W-1:0] byte_index_ff, byte_index_in;
   logic [LEN_W-1:0]   body_length_ff, body_length_in;
   logic [LEN_W-1:0]   payload_expect_ff, payload_expect_in;
   logic [LEN_W-1:0]   payload_remaining_ff, payload_remaining_in;
   logic [MAGIC_W-1:0] got_magic_ff, got_magic_in;
   logic [VER_W-1:0]   got_version_ff, got_version_in;
   logic [TYPE_W-1:0]  got_type_ff, got_type_in;
   logic [PLEN_W-1:0]  got_payload_length_ff, got_payload_length_in;
   logic [RID_W-1:0]   got_request_tag_ff, got_request_tag_in;

   // output register
   rsp_type rsp_ff, rsp_in;
   logic    rsp_valid_ff, rsp_valid_in;

   logic                  req_accept;
   logic                  csr_write;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [BYTE_W-1:0]     b;
   logic [2:0]            rid_lane;
   logic [MAGIC_W-1:0]    body_full;
   logic [LEN_W:0]        length_limit;
   logic                  length_bad;
   logic [LEN_W-1:0]      body_expect;
   status_type            hdr_status;
   rsp_type               result;
   logic                  result_valid;

   // take a beat whenever the output register is free or drains this cycle
   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign req_accept   = req_if.valid && req_if.ready;
   assign b            = req_if.data_byte;

   // ------------------------------------------------------------------
   // configuration port
   // ------------------------------------------------------------------
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = paddr[CSR_ADDR_W-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         magic_word_ff       <= '0;
         expected_version_ff <= '0;
         max_payload_ff      <= MAX_PAYLOAD_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_MAGIC_WORD:       magic_word_ff       <= pwdata;
            CSR_EXPECTED_VERSION: expected_version_ff <= pwdata[VER_W-1:0];
            CSR_MAX_PAYLOAD:      max_payload_ff      <= pwdata[LEN_W-1:0];
            default:              ;
         endcase
      end
   end

   // read back, zero-extended
   always_comb begin
      case (csr_index)
         CSR_MAGIC_WORD:       prdata = magic_word_ff;
         CSR_EXPECTED_VERSION: prdata = CSR_DATA_W'(expected_version_ff);
         CSR_MAX_PAYLOAD:      prdata = CSR_DATA_W'(max_payload_ff);
         default:              prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------
   // checks on the completed length and header
   // ------------------------------------------------------------------
   assign body_full    = {b, body_length_ff};
   assign length_limit = {1'b0, max_payload_ff} + (LEN_W+1)'(HEADER_BYTES);
   assign length_bad   = (body_full < MAGIC_W'(HEADER_BYTES))
                      || (body_full > MAGIC_W'(length_limit));
   assign body_expect  = body_full[LEN_W-1:0] - LEN_W'(HEADER_BYTES);
   assign rid_lane     = 3'(byte_index_ff - HDR_RID_OFS);

   always_comb begin
      if (got_magic_ff != magic_word_ff) begin
         hdr_status = ST_BAD_MAGIC;
      end else if (got_version_ff != expected_version_ff) begin
         hdr_status = ST_BAD_VERSION;
      end else if (got_payload_length_ff != PLEN_W'(payload_expect_ff)) begin
         hdr_status = ST_MISMATCH;
      end else begin
         hdr_status = ST_OK;
      end
   end

   // ------------------------------------------------------------------
   // frame state update for one beat
   // ------------------------------------------------------------------
   always_comb begin
      phase_in              = phase_ff;
      byte_index_in         = byte_index_ff;
      body_length_in        = body_length_ff;
      payload_expect_in     = payload_expect_ff;
      payload_remaining_in  = payload_remaining_ff;
      got_magic_in          = got_magic_ff;
      got_version_in        = got_version_ff;
      got_type_in           = got_type_ff;
      got_payload_length_in = got_payload_length_ff;
      got_request_tag_in    = got_request_tag_ff;
      result                = '0;
      result_valid          = 1'b0;

      if (req_accept) begin
         if (req_if.restart) begin
            // drop the frame in progress
            phase_in             = PH_LENGTH;
            byte_index_in        = '0;
            payload_remaining_in = '0;
         end else begin
            case (phase_ff)
               PH_LENGTH: begin
                  case (byte_index_ff[1:0])
                     2'd0:    body_length_in[7:0]   = b;
                     2'd1:    body_length_in[15:8]  = b;
                     2'd2:    body_length_in[23:16] = b;
                     default: ;
                  endcase
                  if (byte_index_ff != LAST_LENGTH_INDEX) begin
                     byte_index_in = byte_index_ff + 1'b1;
                  end else if (length_bad) begin
                     // report and resync, header fields stay zero
                     byte_index_in       = '0;
                     result_valid        = 1'b1;
                     result.frame_end    = 1'b1;
                     result.status       = ST_BAD_LENGTH;
                  end else begin
                     byte_index_in     = '0;
                     payload_expect_in = body_expect;
                     phase_in          = PH_HEADER;
                  end
               end

               PH_HEADER: begin
                  // capture the little-endian header fields
                  case (byte_index_ff) inside
                     [0:3]:   got_magic_in[8*byte_index_ff[1:0] +: 8] = b;
                     [4:5]:   got_version_in[8*byte_index_ff[0] +: 8] = b;
                     [6:7]:   got_type_in[8*byte_index_ff[0] +: 8]    = b;
                     [8:11]:  got_payload_length_in[8*byte_index_ff[1:0] +: 8] = b;
                     [12:19]: got_request_tag_in[8*rid_lane +: 8] = b;
                     default: ;
                  endcase
                  if (byte_index_ff != LAST_HEADER_INDEX) begin
                     byte_index_in = byte_index_ff + 1'b1;
                  end else begin
                     byte_index_in = '0;
                     if (hdr_status != ST_OK || payload_expect_ff == '0) begin
                        // verdict now: error or empty payload
                        phase_in              = PH_LENGTH;
                        result_valid          = 1'b1;
                        result.frame_end      = 1'b1;
                        result.status         = hdr_status;
                        result.command_type   = got_type_ff;
                        result.header_version = got_version_ff;
                        result.payload_length = got_payload_length_ff[LEN_W-1:0];
                        result.request_tag    = got_request_tag_in;
                     end else begin
                        phase_in             = PH_PAYLOAD;
                        payload_remaining_in = payload_expect_ff;
                     end
                  end
               end

               PH_PAYLOAD: begin
                  // pass the byte on, close the frame on the last one
                  payload_remaining_in = payload_remaining_ff - 1'b1;
                  result_valid         = 1'b1;
                  result.payload_byte  = b;
                  result.byte_valid    = 1'b1;
                  if (payload_remaining_in == '0) begin
                     phase_in              = PH_LENGTH;
                     byte_index_in         = '0;
                     result.frame_end      = 1'b1;
                     result.status         = ST_OK;
                     result.command_type   = got_type_ff;
                     result.header_version = got_version_ff;
                     result.payload_length = got_payload_length_ff[LEN_W-1:0];
                     result.request_tag    = got_request_tag_ff;
                  end
               end

               default: begin
                  phase_in             = PH_LENGTH;
                  byte_index_in        = '0;
                  payload_remaining_in = '0;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff             <= PH_LENGTH;
         byte_index_ff        <= '0;
         payload_remaining_ff <= '0;
      end else begin
         phase_ff             <= phase_in;
         byte_index_ff        <= byte_index_in;
         payload_remaining_ff <= payload_remaining_in;
      end
   end

   // every field byte is rewritten before it is read, so no clear needed
   always_ff @(posedge clock) begin
      body_length_ff        <= body_length_in;
      payload_expect_ff     <= payload_expect_in;
      got_magic_ff          <= got_magic_in;
      got_version_ff        <= got_version_in;
      got_type_ff           <= got_type_in;
      got_payload_length_ff <= got_payload_length_in;
      got_request_tag_ff    <= got_request_tag_in;
   end

   // ------------------------------------------------------------------
   // output register: hold while stalled, load a new result
   // ------------------------------------------------------------------
   assign rsp_valid_in = (rsp_valid_ff && !rsp_if.ready) || result_valid;
   assign rsp_in       = result_valid ? result : rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.payload_byte   = rsp_ff.payload_byte;
   assign rsp_if.byte_valid     = rsp_ff.byte_valid;
   assign rsp_if.frame_end      = rsp_ff.frame_end;
   assign rsp_if.status         = rsp_ff.status;
   assign rsp_if.command_type   = rsp_ff.command_type;
   assign rsp_if.header_version = rsp_ff.header_version;
   assign rsp_if.payload_length = rsp_ff.payload_length;
   assign rsp_if.request_tag    = rsp_ff.request_tag;

   // ------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------
   `LPCD_ASSERT_IMP(a_payload_has_bytes_left, clock, reset, phase_ff == PH_PAYLOAD, payload_remaining_ff != '0)
   `LPCD_ASSERT_IMP(a_header_index_in_range, clock, reset, phase_ff == PH_HEADER, byte_index_ff <= LAST_HEADER_INDEX)
   `LPCD_ASSERT_IMP(a_bad_length_no_fields, clock, reset, rsp_valid_ff && rsp_ff.status == ST_BAD_LENGTH, !rsp_ff.byte_valid && rsp_ff.request_tag == '0 && rsp_ff.payload_length == '0)
   `LPCD_ASSERT_NXT(a_payload_beat_gives_result, clock, reset, req_accept && !req_if.restart && phase_ff == PH_PAYLOAD, rsp_valid_ff && rsp_ff.byte_valid)
   `LPCD_ASSERT_NXT(a_restart_clears_frame, clock, reset, req_accept && req_if.restart, phase_ff == PH_LENGTH && byte_index_ff == '0)

endmodule

// ----- dv/tb_length_prefixed_command_deframer.sv -----
// ----------------------------------------------------------------------------
// tb_length_prefixed_command_deframer
// Self-checking bench for the command frame deframer. It feeds a byte stream
// of well-formed frames, header errors, bad lengths, restarts and noise under
// several register settings. An in-bench frame parser predicts every payload
// beat and verdict, and the bench compares them in order with the block's
// result channel while both channels idle at random.
// ----------------------------------------------------------------------------
module tb_length_prefixed_command_deframer import lpcd_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned NUM_SETTINGS = 5;
   localparam int unsigned PHASE_BEATS = 220;
   // register setting whose first write lands in the middle of a frame
   localparam int unsigned MID_FRAME_SETTING = 3;

   typedef enum {
      FR_GOOD,
      FR_BAD_MAGIC,
      FR_BAD_VERSION,
      FR_MISMATCH,
      FR_SHORT_LEN,
      FR_LONG_LEN
   } frame_kind_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              restart;
   } stream_beat_type;

   typedef struct packed {
      logic [MAGIC_W-1:0] magic;
      logic [VER_W-1:0]   version;
      logic [LEN_W-1:0]   max_payload;
   } csr_setting_type;

   logic clock;
   logic reset;
   logic psel;
   logic penable;
   logic pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic pready;

   lpcd_req_if req_bus ();
   lpcd_rsp_if rsp_bus ();

   length_prefixed_command_deframer i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_if  (req_bus),
      .rsp_if  (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // stimulus and expected results
   stream_beat_type stream_q[$];
   logic [BYTE_W-1:0] frame_buf[$];
   rsp_type expected_rsp_q[$];
   int unsigned data_beats;
   int unsigned error_count;
   int unsigned cycle_count;
   int unsigned send_gap;
   int unsigned ready_stall;
   bit quiet_tail;
   stream_beat_type next_beat;
   csr_setting_type settings[NUM_SETTINGS];

   // register copy
   logic [MAGIC_W-1:0] cfg_magic;
   logic [VER_W-1:0]   cfg_version;
   logic [LEN_W-1:0]   cfg_max_payload;

   // frame parser state
   phase_type          fr_phase;
   logic [INDEX_W-1:0] fr_index;
   logic [31:0]        body_len;
   logic [LEN_W-1:0]   pay_left;
   logic [MAGIC_W-1:0] hdr_magic;
   logic [VER_W-1:0]   hdr_version;
   logic [TYPE_W-1:0]  hdr_type;
   logic [PLEN_W-1:0]  hdr_plen;
   logic [RID_W-1:0]   hdr_rid;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Frame parser
   // ------------------------------------------------------------------------
   function automatic void drop_frame();
      fr_phase = PH_LENGTH;
      fr_index = '0;
      body_len = '0;
      pay_left = '0;
      hdr_magic = '0;
      hdr_version = '0;
      hdr_type = '0;
      hdr_plen = '0;
      hdr_rid = '0;
   endfunction

   function automatic rsp_type verdict(input status_type st);
      rsp_type r;
      r = '0;
      r.frame_end = 1'b1;
      r.status = st;
      r.command_type = hdr_type;
      r.header_version = hdr_version;
      r.payload_length = hdr_plen[LEN_W-1:0];
      r.request_tag = hdr_rid;
      return r;
   endfunction

   function automatic void deframe_beat(input logic [BYTE_W-1:0] b, input logic restart_beat);
      rsp_type r;
      logic [31:0] want_plen;
      status_type st;
      int unsigned i;
      if (restart_beat) begin
         drop_frame();
         return;
      end
      if (fr_phase == PH_HEADER) begin
         // collect little-endian header fields
         i = fr_index;
         if (i < 4)
            hdr_magic |= 32'(b) << (8 * i);
         else if (i < 6)
            hdr_version |= 16'(b) << (8 * (i - 4));
         else if (i < 8)
            hdr_type |= 16'(b) << (8 * (i - 6));
         else if (i < 12)
            hdr_plen |= 32'(b) << (8 * (i - 8));
         else
            hdr_rid |= 64'(b) << (8 * (i - 12));
         fr_index = INDEX_W'(i + 1);
         if (i + 1 < HEADER_BYTES)
            return;
         want_plen = body_len - 32'(HEADER_BYTES);
         if (hdr_magic != cfg_magic)
            st = ST_BAD_MAGIC;
         else if (hdr_version != cfg_version)
            st = ST_BAD_VERSION;
         else if (hdr_plen != want_plen)
            st = ST_MISMATCH;
         else
            st = ST_OK;
         if (st != ST_OK || want_plen == 0) begin
            expected_rsp_q.insert(expected_rsp_q.size(), verdict(st));
            drop_frame();
         end else begin
            pay_left = want_plen[LEN_W-1:0];
            fr_phase = PH_PAYLOAD;
            fr_index = '0;
         end
      end else if (fr_phase == PH_PAYLOAD) begin
         // pass the byte on; the last one carries the verdict
         pay_left = pay_left - 1'b1;
         if (pay_left == 0) begin
            r = verdict(ST_OK);
            drop_frame();
         end else begin
            r = '0;
         end
         r.payload_byte = b;
         r.byte_valid = 1'b1;
         expected_rsp_q.insert(expected_rsp_q.size(), r);
      end else begin
         // body length, checked once all four bytes are in
         i = fr_index[1:0];
         body_len |= 32'(b) << (8 * i);
         fr_index = INDEX_W'(i + 1);
         if (fr_index < 4)
            return;
         if (body_len < HEADER_BYTES ||
             64'(body_len) > 64'(HEADER_BYTES) + 64'(cfg_max_payload)) begin
            r = '0;
            r.frame_end = 1'b1;
            r.status = ST_BAD_LENGTH;
            expected_rsp_q.insert(expected_rsp_q.size(), r);
            drop_frame();
         end else begin
            fr_phase = PH_HEADER;
            fr_index = '0;
         end
      end
   endfunction

   // ------------------------------------------------------------------------
   // Stream builders
   // ------------------------------------------------------------------------
   function automatic void push_data(input logic [BYTE_W-1:0] b);
      stream_q.insert(stream_q.size(), {b, 1'b0});
      data_beats++;
   endfunction

   function automatic void push_restart();
      stream_q.insert(stream_q.size(), {8'($urandom), 1'b1});
   endfunction

   function automatic void queue_frame_bytes(input int unsigned n);
      repeat (n) push_data(frame_buf.pop_front());
   endfunction

   // build one frame into frame_buf; error frames stop where the block resyncs
   function automatic void build_frame(input frame_kind_type kind, input int unsigned plen,
                                       input logic [MAGIC_W-1:0] magic,
                                       input logic [VER_W-1:0] version);
      logic [31:0] body;
      logic [PLEN_W-1:0] plen_field;
      logic [8*HEADER_BYTES-1:0] hdr;
      frame_buf.delete();
      body = 32'(HEADER_BYTES) + 32'(plen);
      plen_field = PLEN_W'(plen);
      case (kind)
         FR_BAD_MAGIC: magic ^= $urandom_range(1, 32'hffff_ffff);
         FR_BAD_VERSION: version ^= 16'($urandom_range(1, 16'hffff));
         FR_MISMATCH: begin
            // sometimes differ only above the reported 24 bits
            if ($urandom_range(0, 1) == 0)
               plen_field ^= {8'($urandom_range(1, 255)), 24'h0};
            else
               plen_field ^= $urandom_range(1, 32'hffff_ffff);
         end
         FR_SHORT_LEN: body = $urandom_range(0, HEADER_BYTES - 1);
         FR_LONG_LEN: begin
            if ($urandom_range(0, 3) == 0)
               body = 32'hffff_ffff;
            else
               body = 32'(HEADER_BYTES) + 32'(cfg_max_payload) + 1 + $urandom_range(0, 7);
         end
         default: ;
      endcase
      for (int k = 0; k < 4; k++)
         frame_buf.insert(frame_buf.size(), body[8*k +: 8]);
      if (kind == FR_SHORT_LEN || kind == FR_LONG_LEN)
         return;
      hdr = {$urandom, $urandom, plen_field, 16'($urandom), version, magic};
      for (int k = 0; k < HEADER_BYTES; k++)
         frame_buf.insert(frame_buf.size(), hdr[8*k +: 8]);
      if (kind == FR_GOOD)
         repeat (plen) frame_buf.insert(frame_buf.size(), 8'($urandom));
   endfunction

   task automatic random_traffic(input int unsigned n_beats);
      int unsigned goal;
      int unsigned pick;
      int unsigned plen;
      int unsigned cap;
      frame_kind_type kind;
      goal = data_beats + n_beats;
      while (data_beats < goal) begin
         pick = $urandom_range(0, 99);
         // mostly short payloads, now and then a long one or the limit
         cap = (cfg_max_payload < 12) ? cfg_max_payload : 12;
         plen = $urandom_range(0, cap);
         if ($urandom_range(0, 15) == 0)
            plen = (cfg_max_payload < 300) ? cfg_max_payload : $urandom_range(13, 300);
         if (pick < 55) begin
            build_frame(FR_GOOD, plen, cfg_magic, cfg_version);
            queue_frame_bytes(frame_buf.size());
         end else if (pick < 76) begin
            if (pick < 62)
               kind = FR_BAD_MAGIC;
            else if (pick < 69)
               kind = FR_BAD_VERSION;
            else
               kind = FR_MISMATCH;
            if ($urandom_range(0, 3) == 0)
               plen = cfg_max_payload;
            build_frame(kind, plen, cfg_magic, cfg_version);
            queue_frame_bytes(frame_buf.size());
         end else if (pick < 86) begin
            kind = (pick < 81) ? FR_SHORT_LEN : FR_LONG_LEN;
            build_frame(kind, 0, cfg_magic, cfg_version);
            queue_frame_bytes(frame_buf.size());
         end else if (pick < 94) begin
            // cut a good frame short with a restart
            build_frame(FR_GOOD, plen, cfg_magic, cfg_version);
            queue_frame_bytes($urandom_range(1, frame_buf.size() - 1));
            push_restart();
            frame_buf.delete();
         end else begin
            // line noise, then resync
            repeat ($urandom_range(1, 10)) push_data(8'($urandom));
            push_restart();
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Register port
   // ------------------------------------------------------------------------
   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx, input logic [31:0] value);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= CSR_ADDR_W'(4 * idx);
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (idx)
         CSR_MAGIC_WORD: cfg_magic = value;
         CSR_EXPECTED_VERSION: cfg_version = value[VER_W-1:0];
         CSR_MAX_PAYLOAD: cfg_max_payload = value[LEN_W-1:0];
         default: ;
      endcase
   endtask

   // hold until the stream is sent and every result is back, with both channels idle
   task automatic wait_drained();
      int unsigned idle_edges;
      idle_edges = 0;
      while (idle_edges < 4) begin
         @(posedge clock);
         if (stream_q.size() != 0 || req_bus.valid || rsp_bus.valid ||
             expected_rsp_q.size() != 0)
            idle_edges = 0;
         else
            idle_edges++;
      end
   endtask

   // ------------------------------------------------------------------------
   // Input driver
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_bus.data_byte <= '0;
         req_bus.restart <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_bus.valid && req_bus.ready)
            deframe_beat(req_bus.data_byte, req_bus.restart);
         // advance to the next beat once the current one is taken
         if (!req_bus.valid || req_bus.ready) begin
            if (send_gap == 0 && !quiet_tail && $urandom_range(0, 15) == 0)
               send_gap = $urandom_range(1, 10);
            if (send_gap != 0) begin
               send_gap--;
               req_bus.valid <= 1'b0;
            end else if (stream_q.size() != 0) begin
               next_beat = stream_q.pop_front();
               req_bus.valid <= 1'b1;
               req_bus.data_byte <= next_beat.data_byte;
               req_bus.restart <= next_beat.restart;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Result monitor
   // ------------------------------------------------------------------------
   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0h got %0h", $time, name, want, got);
         error_count++;
      end
   endtask

   task automatic check_result();
      rsp_type want;
      if (expected_rsp_q.size() == 0) begin
         $display("%0t: result beat expected none got byte %0h end %0b status %0d", $time,
                  rsp_bus.payload_byte, rsp_bus.frame_end, rsp_bus.status);
         error_count++;
         return;
      end
      want = expected_rsp_q.pop_front();
      check_field("payload_byte", 64'(want.payload_byte), 64'(rsp_bus.payload_byte));
      check_field("byte_valid", 64'(want.byte_valid), 64'(rsp_bus.byte_valid));
      check_field("frame_end", 64'(want.frame_end), 64'(rsp_bus.frame_end));
      check_field("status", 64'(want.status), 64'(rsp_bus.status));
      check_field("command_type", 64'(want.command_type), 64'(rsp_bus.command_type));
      check_field("header_version", 64'(want.header_version), 64'(rsp_bus.header_version));
      check_field("payload_length", 64'(want.payload_length), 64'(rsp_bus.payload_length));
      check_field("request_tag", want.request_tag, rsp_bus.request_tag);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         ready_stall = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready)
            check_result();
         if (ready_stall == 0 && !quiet_tail && $urandom_range(0, 15) == 0)
            ready_stall = $urandom_range(1, 10);
         if (ready_stall != 0) begin
            ready_stall--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Watchdog
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d results outstanding", $time, expected_rsp_q.size());
         $display("length_prefixed_command_deframer test failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------
   initial begin
      reset = 1'b1;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      req_bus.valid = 1'b0;
      req_bus.data_byte = '0;
      req_bus.restart = 1'b0;
      rsp_bus.ready = 1'b0;
      data_beats = 0;
      error_count = 0;
      cycle_count = 0;
      quiet_tail = 1'b0;
      cfg_magic = '0;
      cfg_version = '0;
      cfg_max_payload = MAX_PAYLOAD_RESET;
      drop_frame();

      // register settings: reset values, a tight limit, all ones, all zeros, random words with the reset limit
      settings[0] = {32'h0, 16'h0, MAX_PAYLOAD_RESET};
      settings[1] = {$urandom, 16'($urandom), 24'd8};
      settings[2] = {32'hffff_ffff, 16'hffff, 24'hff_ffff};
      settings[3] = {32'h0, 16'h0, 24'h0};
      settings[4] = {$urandom, 16'($urandom), 24'd65536};

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: empty frame, zero length, all-ones length, lone restart
      build_frame(FR_GOOD, 0, cfg_magic, cfg_version);
      queue_frame_bytes(frame_buf.size());
      repeat (4) push_data(8'h00);
      repeat (4) push_data(8'hff);
      push_restart();
      random_traffic(PHASE_BEATS);

      for (int p = 1; p < NUM_SETTINGS; p++) begin
         // leave a frame open across the register change
         if (p == MID_FRAME_SETTING) begin
            build_frame(FR_GOOD, 5, settings[p].magic, settings[p].version);
            queue_frame_bytes(7);
         end
         wait_drained();
         if (p == NUM_SETTINGS - 1)
            quiet_tail = 1'b1;
         csr_write(CSR_MAGIC_WORD, settings[p].magic);
         csr_write(CSR_EXPECTED_VERSION, {16'($urandom), settings[p].version});
         csr_write(CSR_MAX_PAYLOAD, {8'($urandom), settings[p].max_payload});
         queue_frame_bytes(frame_buf.size());
         random_traffic(PHASE_BEATS);
      end

      wait_drained();
      repeat (5) @(posedge clock);
      if (error_count == 0) begin
         $display("length_prefixed_command_deframer test passed");
      end else begin
         $display("length_prefixed_command_deframer test failed");
      end
      $finish;
   end

endmodule
